// ----- hw/rtl/htiq_pkg.sv -----
package htiq_pkg;

    // configuration port
    localparam int unsigned CFG_DATA_W  = 64;
    localparam int unsigned CFG_INDEX_W = 3;

    // register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_IDX_MAGIC   = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_IDX_VERSION = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_IDX_PRESS   = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_IDX_RELEASE = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_IDX_STALE   = 3'd4;

    // register reset values (q15 thresholds, timeout in ns)
    localparam logic [14:0] PRESS_RESET   = 15'd11469;
    localparam logic [14:0] RELEASE_RESET = 15'd6553;
    localparam logic [63:0] STALE_RESET   = 64'd250000000;

    // item kinds
    localparam logic MODE_PACKET = 1'b0;
    localparam logic MODE_POLL   = 1'b1;

    typedef struct packed {
        logic               mode;
        logic [63:0]        now_time;
        logic [31:0]        magic_value;
        logic [7:0]         version_value;
        logic [15:0]        sequence_req;
        logic signed [15:0] move_x;
        logic signed [15:0] move_y;
        logic               move_valid;
        logic               aim_valid_in;
        logic               focus_button;
        logic               shoot_button;
        logic [15:0]        aim_code;
    } item_t;

    typedef struct packed {
        logic        left_held;
        logic        right_held;
        logic        up_held;
        logic        down_held;
        logic        focus_held;
        logic        shoot_held;
        logic        aim_present;
        logic [15:0] aim_out;
    } result_t;

    typedef struct packed {
        logic [31:0] expected_magic;
        logic [7:0]  expected_version;
        logic [14:0] press_threshold;
        logic [14:0] release_threshold;
        logic [63:0] stale_timeout;
    } cfg_t;

    // key pair of one axis
    typedef struct packed {
        logic neg;
        logic pos;
    } axis_keys_t;

endpackage

// ----- hw/rtl/htiq_axis.sv -----
module htiq_axis (
    input  htiq_pkg::axis_keys_t keys,
    input  logic signed [15:0]   value,
    input  logic [14:0]          press_level,
    input  logic [14:0]          release_level,
    output htiq_pkg::axis_keys_t keys_next
);
    import htiq_pkg::*;

    logic signed [16:0] val_s;
    logic signed [16:0] press_s;
    logic signed [16:0] rel_s;
    logic signed [16:0] mag_s;

    // widen to 17 bits so that the negated press level and |-32768| fit
    assign val_s   = $signed({value[15], value});
    assign press_s = $signed({2'b00, press_level});
    assign rel_s   = $signed({2'b00, release_level});
    assign mag_s   = val_s[16] ? -val_s : val_s;

    // press / release hysteresis, checked in priority order
    always_comb
    begin
        keys_next = keys;
        if (val_s <= -press_s)
        begin
            keys_next.neg = 1'b1;
            keys_next.pos = 1'b0;
        end
        else if (val_s >= press_s)
        begin
            keys_next.neg = 1'b0;
            keys_next.pos = 1'b1;
        end
        else if (mag_s <= rel_s)
        begin
            keys_next.neg = 1'b0;
            keys_next.pos = 1'b0;
        end
    end

endmodule

// ----- hw/rtl/htiq_core.sv -----
module htiq_core (
    input  logic              clk,
    input  logic              rst_n,
    input  htiq_pkg::cfg_t    cfg,
    input  logic              fire,
    input  htiq_pkg::item_t   item,
    output htiq_pkg::result_t report
);
    import htiq_pkg::*;

    logic [15:0] prev_seq_reg, prev_seq_next;
    logic        have_seq_reg, have_seq_next;
    logic [63:0] last_time_reg, last_time_next;
    logic [4:0]  held_reg, held_next;
    logic        shoot_reg, shoot_next;
    logic [15:0] aim_reg, aim_next;
    logic        aim_valid_reg, aim_valid_next;
    logic        drain_reg, drain_next;

    logic [15:0] seq_diff;
    logic        seq_newer;
    logic        pkt_ok;
    logic [63:0] elapsed;
    logic        stale;
    axis_keys_t  x_keys, x_keys_next;
    axis_keys_t  y_keys, y_keys_next;
    logic [4:0]  held_pkt;
    logic [4:0]  held_rep;
    logic        shoot_rep;
    logic        aim_valid_rep;

    // packet qualification: magic, version, wraparound sequence order
    assign seq_diff  = item.sequence_req - prev_seq_reg;
    assign seq_newer = (seq_diff != 16'd0) && !seq_diff[15];
    assign pkt_ok    = (item.magic_value == cfg.expected_magic)
                    && (item.version_value == cfg.expected_version)
                    && (!drain_reg || seq_newer);

    // staleness on a poll
    assign elapsed = item.now_time - last_time_reg;
    assign stale   = !have_seq_reg || (elapsed > cfg.stale_timeout);

    // bit 0 left, 1 right, 2 up, 3 down, 4 focus
    assign x_keys.neg = held_reg[0];
    assign x_keys.pos = held_reg[1];
    assign y_keys.neg = held_reg[2];
    assign y_keys.pos = held_reg[3];

    htiq_axis u_axis_x (
        .keys          (x_keys),
        .value         (item.move_x),
        .press_level   (cfg.press_threshold),
        .release_level (cfg.release_threshold),
        .keys_next     (x_keys_next)
    );

    htiq_axis u_axis_y (
        .keys          (y_keys),
        .value         (item.move_y),
        .press_level   (cfg.press_threshold),
        .release_level (cfg.release_threshold),
        .keys_next     (y_keys_next)
    );

    // untracked hand releases all direction keys and focus
    assign held_pkt = item.move_valid
                    ? {item.focus_button, y_keys_next.pos, y_keys_next.neg,
                       x_keys_next.pos, x_keys_next.neg}
                    : 5'd0;

    // report as seen after the staleness clear
    assign held_rep      = stale ? 5'd0 : held_reg;
    assign shoot_rep     = stale ? 1'b0 : shoot_reg;
    assign aim_valid_rep = stale ? 1'b0 : aim_valid_reg;

    always_comb
    begin
        report.left_held   = held_rep[0];
        report.right_held  = held_rep[1];
        report.up_held     = held_rep[2];
        report.down_held   = held_rep[3];
        report.focus_held  = held_rep[4];
        report.shoot_held  = shoot_rep;
        report.aim_present = aim_valid_rep;
        report.aim_out     = aim_valid_rep ? aim_reg : 16'd0;
    end

    // state update for the item leaving the input register
    always_comb
    begin
        prev_seq_next  = prev_seq_reg;
        have_seq_next  = have_seq_reg;
        last_time_next = last_time_reg;
        held_next      = held_reg;
        shoot_next     = shoot_reg;
        aim_next       = aim_reg;
        aim_valid_next = aim_valid_reg;
        drain_next     = drain_reg;
        if (fire)
        begin
            if (item.mode == MODE_PACKET)
            begin
                if (pkt_ok)
                begin
                    drain_next     = 1'b1;
                    prev_seq_next  = item.sequence_req;
                    have_seq_next  = 1'b1;
                    last_time_next = item.now_time;
                    held_next      = held_pkt;
                    shoot_next     = item.shoot_button;
                    aim_valid_next = item.aim_valid_in;
                    if (item.aim_valid_in)
                    begin
                        aim_next = item.aim_code;
                    end
                end
            end
            else
            begin
                drain_next     = 1'b0;
                held_next      = held_rep;
                shoot_next     = shoot_rep;
                aim_valid_next = aim_valid_rep;
            end
        end
    end

    // tracker state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_seq_reg  <= '0;
            have_seq_reg  <= 1'b0;
            last_time_reg <= '0;
            held_reg      <= '0;
            shoot_reg     <= 1'b0;
            aim_reg       <= '0;
            aim_valid_reg <= 1'b0;
            drain_reg     <= 1'b0;
        end
        else
        begin
            prev_seq_reg  <= prev_seq_next;
            have_seq_reg  <= have_seq_next;
            last_time_reg <= last_time_next;
            held_reg      <= held_next;
            shoot_reg     <= shoot_next;
            aim_reg       <= aim_next;
            aim_valid_reg <= aim_valid_next;
            drain_reg     <= drain_next;
        end
    end

endmodule

// ----- hw/rtl/hand_tracker_input_qualifier.sv -----
// channel   direction  handshake              payload
// in        input      in_valid / in_ready    in_item  (packet or poll)
// out       output     out_valid / out_ready  out_item (held-key report)
// cfg       input      cfg_write              cfg_index, cfg_data
//
// one item per cycle while no poll is blocked: input register, then one pass of compare logic that
// updates the tracker state; a poll's report lands in the result register.
// out_valid rises once a poll leaves the input register and its report is registered.
// a poll waits in the input register only while the result register is
// full and out_ready is low; packets never wait. no clearing pass after reset.
module hand_tracker_input_qualifier (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  htiq_pkg::item_t                      in_item,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output htiq_pkg::result_t                    out_item,
    input  logic                                 cfg_write,
    input  logic [htiq_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [htiq_pkg::CFG_DATA_W-1:0]      cfg_data
);
    import htiq_pkg::*;

    cfg_t    cfg_reg;
    logic    stage_valid_reg;
    item_t   stage_item_reg;
    logic    out_valid_reg;
    result_t out_item_reg;
    logic    stage_go;
    logic    stage_poll;
    result_t report;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.expected_magic    <= '0;
            cfg_reg.expected_version  <= '0;
            cfg_reg.press_threshold   <= PRESS_RESET;
            cfg_reg.release_threshold <= RELEASE_RESET;
            cfg_reg.stale_timeout     <= STALE_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_IDX_MAGIC:   cfg_reg.expected_magic    <= cfg_data[31:0];
                CFG_IDX_VERSION: cfg_reg.expected_version  <= cfg_data[7:0];
                CFG_IDX_PRESS:   cfg_reg.press_threshold   <= cfg_data[14:0];
                CFG_IDX_RELEASE: cfg_reg.release_threshold <= cfg_data[14:0];
                CFG_IDX_STALE:   cfg_reg.stale_timeout     <= cfg_data;
                default: ;
            endcase
        end
    end

    // input register moves on unless a poll finds the result register blocked
    assign stage_poll = stage_item_reg.mode == MODE_POLL;
    assign stage_go   = stage_valid_reg && (!stage_poll || !out_valid_reg || out_ready);
    assign in_ready   = !stage_valid_reg || stage_go;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
        end
        else if (in_valid && in_ready)
        begin
            stage_valid_reg <= 1'b1;
        end
        else if (stage_go)
        begin
            stage_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            stage_item_reg <= in_item;
        end
    end

    htiq_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg_reg),
        .fire   (stage_go),
        .item   (stage_item_reg),
        .report (report)
    );

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (stage_go && stage_poll)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (stage_go && stage_poll)
        begin
            out_item_reg <= report;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

    // a blocked poll must hold off new transfers
    a_poll_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        (stage_valid_reg && stage_poll && out_valid_reg && !out_ready) |-> !in_ready)
        else $error("input accepted while a poll is blocked");

    // every poll that leaves the input register gives a report
    a_poll_reports: assert property (@(posedge clk) disable iff (!rst_n)
        (stage_go && stage_poll) |=> out_valid_reg)
        else $error("poll left the input register without a report");

    // aim field is zero whenever aim is absent
    a_aim_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_item_reg.aim_present) |-> (out_item_reg.aim_out == 16'd0))
        else $error("aim_out set without aim_present");

    // opposing keys of one axis are never held together
    a_no_opposing: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (!(out_item_reg.left_held && out_item_reg.right_held)
                        && !(out_item_reg.up_held && out_item_reg.down_held)))
        else $error("opposing direction keys held together");

endmodule
